// ===== src/mbox_from_line_checker_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the mbox "From " line checker
// Shared concurrent assertion shapes used by the checker's modules.
// ----------------------------------------------------------------------------
`ifndef MBOX_FROM_LINE_CHECKER_TOP_ASSERT_SVH
`define MBOX_FROM_LINE_CHECKER_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define MFLC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mflc same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define MFLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mflc next-cycle check failed");

`endif

// ===== src/mflc_pkg.sv =====
// ----------------------------------------------------------------------------
// mflc_pkg
// Types, codes, constants and lookup functions of the mbox line checker.
// ----------------------------------------------------------------------------
package mflc_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam logic [3:0] FIELD_LIMIT = 4'd10;
   localparam logic [2:0] PREFIX_LEN = 3'd5;
   localparam int NUMBER_SLOTS = 7;
   localparam logic [3:0] FIRST_NUMBER_FIELD = 4'd3;
   localparam logic [3:0] WEEKDAY_FIELD = 4'd1;
   localparam logic [3:0] MONTH_FIELD = 4'd2;
   localparam logic [3:0] HOUR_FIELD = 4'd4;
   localparam logic [3:0] MINUTE_FIELD = 4'd5;
   localparam logic [11:0] VALUE_CAP = 12'd4095;

   // Verdict codes.
   localparam logic [2:0] VERDICT_MATCH       = 3'd0;
   localparam logic [2:0] VERDICT_BAD_PREFIX  = 3'd1;
   localparam logic [2:0] VERDICT_FEW_FIELDS  = 3'd2;
   localparam logic [2:0] VERDICT_BAD_WEEKDAY = 3'd3;
   localparam logic [2:0] VERDICT_BAD_MONTH   = 3'd4;
   localparam logic [2:0] VERDICT_NOT_DIGIT   = 3'd5;
   localparam logic [2:0] VERDICT_RANGE       = 3'd6;

   // Number indexes: day, hour, minute, second, year.
   localparam int NUM_CHECKS = 5;
   localparam logic [2:0] NUM_YEAR = 3'd4;
   localparam logic [NUM_CHECKS-1:0][11:0] NUM_LOW  =
      {12'd1969, 12'd0, 12'd0, 12'd0, 12'd1};
   localparam logic [NUM_CHECKS-1:0][11:0] NUM_HIGH =
      {12'd2199, 12'd60, 12'd59, 12'd23, 12'd31};

   typedef struct packed {
      logic [7:0] text_byte;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic [2:0] verdict;
      logic [2:0] verdict_detail;
   } rsp_type;

   // One classified byte as it travels through the queue.
   typedef struct packed {
      logic [7:0] text_byte;
      logic       line_end;
      logic       is_term;
      logic       is_high;
      logic       is_blank;
      logic       is_digit;
      logic       is_colon;
      logic [3:0] digit;
   } byte_type;

   // Scanner state; also the snapshot handed to the judge at line end.
   typedef struct packed {
      logic [2:0]                    prefix_matched;
      logic                          prefix_bad;
      logic [3:0]                    fields_seen;
      logic                          inside_token;
      logic [23:0]                   weekday_window;
      logic [1:0]                    weekday_fill;
      logic [23:0]                   month_window;
      logic [1:0]                    month_fill;
      logic [NUMBER_SLOTS-1:0][11:0] number_values;
      logic [NUMBER_SLOTS-1:0]       number_starts_digit;
      logic                          digit_run_active;
      logic                          line_finished;
   } scan_type;

   function automatic logic [7:0] prefix_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0: c = "F";
         3'd1: c = "r";
         3'd2: c = "o";
         3'd3: c = "m";
         3'd4: c = " ";
         default: c = 8'd0;
      endcase
      return c;
   endfunction

   function automatic logic weekday_known(input logic [23:0] w);
      logic hit;
      case (w)
         "Sun", "Mon", "Tue", "Wed", "Thu", "Fri", "Sat": hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic logic month_known(input logic [23:0] w);
      logic hit;
      case (w)
         "Jan", "Feb", "Mar", "Apr", "May", "Jun",
         "Jul", "Aug", "Sep", "Oct", "Nov", "Dec": hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

// ===== src/mflc_front.sv =====
// ----------------------------------------------------------------------------
// mflc_front
// Classifies each incoming byte for the scanner.
// ----------------------------------------------------------------------------
module mflc_front (
   input  mflc_pkg::req_type  req_item,
   output mflc_pkg::byte_type cls_item
);

   logic [7:0] b;

   assign b = req_item.text_byte;

   always_comb begin
      cls_item.text_byte = b;
      cls_item.line_end  = req_item.line_end;
      cls_item.is_term   = (b == 8'd0) || (b == 8'd10);
      cls_item.is_high   = b[7];
      cls_item.is_blank  = (b inside {8'd32, [8'd9:8'd13]});
      cls_item.is_digit  = (b inside {[8'd48:8'd57]});
      cls_item.is_colon  = (b == 8'd58);
      cls_item.digit     = b[3:0];
   end

endmodule

// ===== src/mflc_queue.sv =====
// ----------------------------------------------------------------------------
// mflc_queue
// Small first-in first-out queue between the classifier and the scanner.
// ----------------------------------------------------------------------------
`include "mbox_from_line_checker_top_assert.svh"

module mflc_queue #(
   parameter int DEPTH = mflc_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mflc_pkg::byte_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output mflc_pkg::byte_type head_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   mflc_pkg::byte_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == DEPTH_CNT);
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   `MFLC_ASSERT_IMPLY(a_queue_count_bound, clock, reset, 1'b1, count_ff <= DEPTH_CNT)

endmodule

// ===== src/mflc_back.sv =====
// ----------------------------------------------------------------------------
// mflc_back
// Scanner: prefix match, field split and number capture, one byte a cycle while a byte is queued and no line end waits.
// ----------------------------------------------------------------------------
`include "mbox_from_line_checker_top_assert.svh"

module mflc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  mflc_pkg::byte_type head_item,
   output logic               pop,
   output logic               done_valid,
   output mflc_pkg::scan_type done_scan,
   input  logic               done_ready
);

   mflc_pkg::scan_type st_ff, st_in, nx;
   mflc_pkg::byte_type hb;
   logic [3:0]  idx;
   logic        go;
   logic        was_inside;
   logic [15:0] grown;

   assign hb         = head_item;
   assign pop        = head_valid && (!hb.line_end || done_ready);
   assign done_valid = head_valid && hb.line_end;
   assign done_scan  = nx;

   always_comb begin
      nx         = st_ff;
      idx        = '0;
      go         = 1'b0;
      was_inside = st_ff.inside_token;
      grown      = '0;
      if (!st_ff.prefix_bad && (st_ff.prefix_matched < mflc_pkg::PREFIX_LEN)) begin
         if (hb.text_byte == mflc_pkg::prefix_char(st_ff.prefix_matched)) begin
            nx.prefix_matched = st_ff.prefix_matched + 1'b1;
         end else begin
            nx.prefix_bad = 1'b1;
         end
      end else if (!st_ff.prefix_bad && !st_ff.line_finished) begin
         if (hb.is_term) begin
            nx.line_finished    = 1'b1;
            nx.inside_token     = 1'b0;
            nx.digit_run_active = 1'b0;
         end else if (hb.is_high) begin
            // The remaining fields count as present, empty and non-numeric.
            nx.fields_seen      = mflc_pkg::FIELD_LIMIT;
            nx.line_finished    = 1'b1;
            nx.inside_token     = 1'b0;
            nx.digit_run_active = 1'b0;
         end else if (hb.is_blank) begin
            nx.inside_token     = 1'b0;
            nx.digit_run_active = 1'b0;
         end else if (was_inside) begin
            idx = st_ff.fields_seen - 1'b1;
            go  = 1'b1;
         end else if (st_ff.fields_seen < mflc_pkg::FIELD_LIMIT) begin
            idx             = st_ff.fields_seen;
            go              = 1'b1;
            nx.fields_seen  = st_ff.fields_seen + 1'b1;
            nx.inside_token = 1'b1;
            if (idx < mflc_pkg::FIRST_NUMBER_FIELD) begin
               nx.digit_run_active = 1'b0;
            end
         end

         if (go) begin
            if ((idx == mflc_pkg::WEEKDAY_FIELD) && (st_ff.weekday_fill != 2'd3)) begin
               nx.weekday_window = {st_ff.weekday_window[15:0], hb.text_byte};
               nx.weekday_fill   = st_ff.weekday_fill + 1'b1;
            end else if ((idx == mflc_pkg::MONTH_FIELD) && (st_ff.month_fill != 2'd3)) begin
               nx.month_window = {st_ff.month_window[15:0], hb.text_byte};
               nx.month_fill   = st_ff.month_fill + 1'b1;
            end

            for (int s = 0; s < mflc_pkg::NUMBER_SLOTS; s++) begin
               if (idx == mflc_pkg::FIRST_NUMBER_FIELD + 4'(s)) begin
                  if (!was_inside) begin
                     nx.number_starts_digit[s] = hb.is_digit;
                     nx.number_values[s]       = hb.is_digit ? {8'd0, hb.digit} : 12'd0;
                     nx.digit_run_active       = hb.is_digit;
                  end else if (st_ff.digit_run_active) begin
                     if (hb.is_digit) begin
                        grown = ({4'd0, st_ff.number_values[s]} << 3)
                              + ({4'd0, st_ff.number_values[s]} << 1)
                              + {12'd0, hb.digit};
                        nx.number_values[s] = (grown > {4'd0, mflc_pkg::VALUE_CAP})
                                            ? mflc_pkg::VALUE_CAP : grown[11:0];
                     end else begin
                        nx.digit_run_active = 1'b0;
                     end
                  end
               end
            end

            // A colon closes the hour and minute fields.
            if (hb.is_colon &&
                ((idx == mflc_pkg::HOUR_FIELD) || (idx == mflc_pkg::MINUTE_FIELD))) begin
               nx.inside_token     = 1'b0;
               nx.digit_run_active = 1'b0;
            end
         end
      end

      st_in = st_ff;
      if (pop) begin
         st_in = hb.line_end ? '0 : nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else begin
         st_ff <= st_in;
      end
   end

   `MFLC_ASSERT_IMPLY(a_fields_bound, clock, reset, 1'b1,
                      st_ff.fields_seen <= mflc_pkg::FIELD_LIMIT)
   `MFLC_ASSERT_IMPLY(a_prefix_bound, clock, reset, 1'b1,
                      st_ff.prefix_matched <= mflc_pkg::PREFIX_LEN)
   `MFLC_ASSERT_NEXT(a_clear_after_line, clock, reset, pop && hb.line_end,
                     st_ff == '0)

endmodule

// ===== src/mflc_judge.sv =====
// ----------------------------------------------------------------------------
// mflc_judge
// Holds the end-of-line snapshot and turns it into the result register.
// ----------------------------------------------------------------------------
`include "mbox_from_line_checker_top_assert.svh"

module mflc_judge (
   input  logic               clock,
   input  logic               reset,
   input  logic               done_valid,
   input  mflc_pkg::scan_type done_scan,
   output logic               done_ready,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mflc_pkg::rsp_type  rsp_payload
);

   mflc_pkg::scan_type snap_ff, snap_in;
   logic               snap_valid_ff, snap_valid_in;
   mflc_pkg::rsp_type  rsp_ff, rsp_in, verdict_now;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               snap_move, snap_take;
   logic [2:0]         sel;
   logic [2:0]         slot;
   logic               found;

   assign snap_move   = snap_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign done_ready  = !snap_valid_ff || snap_move;
   assign snap_take   = done_valid && done_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      verdict_now = '0;
      found       = 1'b0;
      slot        = '0;
      // Skip up to two timezone fields when looking for the year.
      sel = mflc_pkg::NUM_YEAR;
      if ((snap_ff.fields_seen > 4'd8) && !snap_ff.number_starts_digit[sel]) begin
         sel = 3'd5;
      end
      if ((snap_ff.fields_seen > 4'd9) && !snap_ff.number_starts_digit[sel]) begin
         sel = 3'd6;
      end
      if (snap_ff.prefix_bad || (snap_ff.prefix_matched < mflc_pkg::PREFIX_LEN)) begin
         verdict_now.verdict = mflc_pkg::VERDICT_BAD_PREFIX;
      end else if (snap_ff.fields_seen < 4'd8) begin
         verdict_now.verdict        = mflc_pkg::VERDICT_FEW_FIELDS;
         verdict_now.verdict_detail = snap_ff.fields_seen[2:0];
      end else if ((snap_ff.weekday_fill != 2'd3) ||
                   !mflc_pkg::weekday_known(snap_ff.weekday_window)) begin
         verdict_now.verdict = mflc_pkg::VERDICT_BAD_WEEKDAY;
      end else if ((snap_ff.month_fill != 2'd3) ||
                   !mflc_pkg::month_known(snap_ff.month_window)) begin
         verdict_now.verdict = mflc_pkg::VERDICT_BAD_MONTH;
      end else begin
         for (int k = 0; k < mflc_pkg::NUM_CHECKS; k++) begin
            slot = (k < mflc_pkg::NUM_CHECKS - 1) ? 3'(k) : sel;
            if (!found) begin
               if (!snap_ff.number_starts_digit[slot]) begin
                  found                      = 1'b1;
                  verdict_now.verdict        = mflc_pkg::VERDICT_NOT_DIGIT;
                  verdict_now.verdict_detail = 3'(k);
               end else if ((snap_ff.number_values[slot] < mflc_pkg::NUM_LOW[k]) ||
                            (snap_ff.number_values[slot] > mflc_pkg::NUM_HIGH[k])) begin
                  found                      = 1'b1;
                  verdict_now.verdict        = mflc_pkg::VERDICT_RANGE;
                  verdict_now.verdict_detail = 3'(k);
               end
            end
         end
      end
   end

   always_comb begin
      snap_in       = snap_take ? done_scan : snap_ff;
      snap_valid_in = snap_take ? 1'b1 : (snap_valid_ff && !snap_move);
      rsp_in        = snap_move ? verdict_now : rsp_ff;
      rsp_valid_in  = snap_move ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
      rsp_ff  <= rsp_in;
   end

   `MFLC_ASSERT_IMPLY(a_detail_only_when_meant, clock, reset,
                      rsp_valid_ff && (rsp_ff.verdict != mflc_pkg::VERDICT_FEW_FIELDS) &&
                      (rsp_ff.verdict != mflc_pkg::VERDICT_NOT_DIGIT) &&
                      (rsp_ff.verdict != mflc_pkg::VERDICT_RANGE),
                      rsp_ff.verdict_detail == 3'd0)

endmodule

// ===== src/mbox_from_line_checker_top.sv =====
// ----------------------------------------------------------------------------
// mbox_from_line_checker_top
// Byte-stream checker that tells whether a text line is an mbox "From " line.
// ----------------------------------------------------------------------------
// The request channel carries one byte of a text line per transfer, with
// line_end set on the final byte. The response channel carries one verdict
// per line, produced only for the transfer that has line_end set; other bytes
// produce nothing. The verdict is a match, a bad prefix, too few fields, a bad
// weekday or month, a number field that does not start with a digit, or a
// number out of range, with the field count or number index as detail.
// Bytes are accepted at one per clock while req_stall is low. A byte goes
// through the classifier into a small queue, and the scanner takes one byte
// per cycle from its head unless a line end waits for the judge, so the
// scanner state update is what sets the rate of one byte per cycle. When
// nothing stalls, the last byte passes the queue, the snapshot register and
// the result register before rsp_valid rises.
// When the receiver stalls, the result register holds, the snapshot register
// fills, the scanner stops at the next line end and the queue fills; only
// then does req_stall rise. Synchronous reset empties the queue, clears the
// scanner and drops both valid flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
module mbox_from_line_checker_top #(
   parameter int QUEUE_DEPTH = mflc_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mflc_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mflc_pkg::rsp_type rsp_payload
);

   // Classified byte on its way into the queue.
   mflc_pkg::byte_type cls_item;

   // Queue head as seen by the scanner.
   mflc_pkg::byte_type head_item;
   logic               head_valid;
   logic               queue_full;
   logic               scan_pop;

   // End-of-line snapshot from the scanner to the judge.
   mflc_pkg::scan_type done_scan;
   logic               done_valid;
   logic               done_ready;

   // The request side only waits when the queue is full.
   assign req_stall = queue_full;

   mflc_front u_front (
      .req_item (req_payload),
      .cls_item (cls_item)
   );

   mflc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_item  (cls_item),
      .full       (queue_full),
      .pop        (scan_pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   mflc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (scan_pop),
      .done_valid (done_valid),
      .done_scan  (done_scan),
      .done_ready (done_ready)
   );

   // The snapshot register lets the scanner start the next line while the
   // previous verdict is still being judged or waits to be taken.
   mflc_judge u_judge (
      .clock       (clock),
      .reset       (reset),
      .done_valid  (done_valid),
      .done_scan   (done_scan),
      .done_ready  (done_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== dv/mflc_verdict_checker.sv =====
// ----------------------------------------------------------------------------
// mflc_verdict_checker
// Watches both channels of the mbox line checker, predicts the verdict of
// every line from the accepted bytes and compares it with each response.
// ----------------------------------------------------------------------------
module mflc_verdict_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  mflc_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  mflc_pkg::rsp_type rsp_payload,
   output int                fail_count,
   output int                pending_verdicts
);

   localparam logic [39:0] FROM_TEXT = "From ";
   localparam logic [6:0][23:0] DAY_CODES =
      {"Sat", "Fri", "Thu", "Wed", "Tue", "Mon", "Sun"};
   localparam logic [11:0][23:0] MONTH_CODES =
      {"Dec", "Nov", "Oct", "Sep", "Aug", "Jul",
       "Jun", "May", "Apr", "Mar", "Feb", "Jan"};
   localparam logic [7:0] CHAR_NUL   = 8'd0;
   localparam logic [7:0] CHAR_NL    = 8'd10;
   localparam logic [7:0] CHAR_COLON = ":";
   localparam logic [7:0] CHAR_ZERO  = "0";
   localparam logic [7:0] CHAR_HIGH  = 8'd128;
   localparam int FULL_FIELDS = mflc_pkg::FIRST_NUMBER_FIELD + mflc_pkg::NUM_CHECKS;
   localparam int REPORT_LIMIT = 10;

   // Shadow copy of the scanner state for the line in progress.
   logic [2:0]  pfx_count;
   logic        pfx_bad;
   logic [3:0]  field_count;
   logic        in_token;
   logic [23:0] wday_win;
   logic [1:0]  wday_fill;
   logic [23:0] mon_win;
   logic [1:0]  mon_fill;
   logic [11:0] num_val [mflc_pkg::NUMBER_SLOTS];
   logic        num_digit [mflc_pkg::NUMBER_SLOTS];
   logic        digit_run;
   logic        line_done;

   mflc_pkg::rsp_type awaited_verdicts[$];
   mflc_pkg::rsp_type want;
   int                mismatches = 0;

   function automatic logic is_space(input logic [7:0] b);
      return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   task automatic clear_scan();
      pfx_count = '0;
      pfx_bad = 1'b0;
      field_count = '0;
      in_token = 1'b0;
      wday_win = '0;
      wday_fill = '0;
      mon_win = '0;
      mon_fill = '0;
      for (int k = 0; k < mflc_pkg::NUMBER_SLOTS; k++) begin
         num_val[k] = '0;
         num_digit[k] = 1'b0;
      end
      digit_run = 1'b0;
      line_done = 1'b0;
   endtask

   // Only the first three bytes of the weekday and month fields are kept.
   task automatic take_window(input int idx, input logic [7:0] b);
      if (idx == mflc_pkg::WEEKDAY_FIELD && wday_fill < 2'd3) begin
         wday_win = {wday_win[15:0], b};
         wday_fill++;
      end else if (idx == mflc_pkg::MONTH_FIELD && mon_fill < 2'd3) begin
         mon_win = {mon_win[15:0], b};
         mon_fill++;
      end
   endtask

   task automatic parse_text(input logic [7:0] b);
      int idx;
      int slot;
      int v;
      if (b == CHAR_NUL || b == CHAR_NL) begin
         line_done = 1'b1;
         in_token = 1'b0;
         digit_run = 1'b0;
         return;
      end
      if (b >= CHAR_HIGH) begin
         // Every remaining field counts as present, empty and non-numeric.
         field_count = mflc_pkg::FIELD_LIMIT;
         line_done = 1'b1;
         in_token = 1'b0;
         digit_run = 1'b0;
         return;
      end
      if (is_space(b)) begin
         in_token = 1'b0;
         digit_run = 1'b0;
         return;
      end
      if (in_token) begin
         idx = int'(field_count) - 1;
         slot = idx - int'(mflc_pkg::FIRST_NUMBER_FIELD);
         take_window(idx, b);
         if (digit_run && slot >= 0 && slot < mflc_pkg::NUMBER_SLOTS) begin
            if (is_digit(b)) begin
               v = int'(num_val[slot]) * 10 + int'(b - CHAR_ZERO);
               num_val[slot] = (v > int'(mflc_pkg::VALUE_CAP)) ? mflc_pkg::VALUE_CAP
                                                               : v[11:0];
            end else begin
               digit_run = 1'b0;
            end
         end
      end else begin
         if (field_count >= mflc_pkg::FIELD_LIMIT) return;
         idx = int'(field_count);
         slot = idx - int'(mflc_pkg::FIRST_NUMBER_FIELD);
         field_count++;
         in_token = 1'b1;
         take_window(idx, b);
         if (slot >= 0 && slot < mflc_pkg::NUMBER_SLOTS) begin
            num_digit[slot] = is_digit(b);
            num_val[slot] = is_digit(b) ? {4'd0, b - CHAR_ZERO} : 12'd0;
            digit_run = is_digit(b);
         end else begin
            digit_run = 1'b0;
         end
      end
      if (b == CHAR_COLON &&
          (idx == mflc_pkg::HOUR_FIELD || idx == mflc_pkg::MINUTE_FIELD)) begin
         in_token = 1'b0;
         digit_run = 1'b0;
      end
   endtask

   task automatic scan_byte(input logic [7:0] b);
      if (!pfx_bad && pfx_count < mflc_pkg::PREFIX_LEN) begin
         if (b == FROM_TEXT[39 - 8 * pfx_count -: 8])
            pfx_count++;
         else
            pfx_bad = 1'b1;
      end else if (!pfx_bad && !line_done) begin
         parse_text(b);
      end
   endtask

   function automatic mflc_pkg::rsp_type line_verdict();
      mflc_pkg::rsp_type r;
      int sel;
      int slot;
      logic day_ok;
      logic month_ok;
      r.verdict = mflc_pkg::VERDICT_MATCH;
      r.verdict_detail = '0;
      if (pfx_bad || pfx_count < mflc_pkg::PREFIX_LEN) begin
         r.verdict = mflc_pkg::VERDICT_BAD_PREFIX;
         return r;
      end
      if (field_count < FULL_FIELDS) begin
         r.verdict = mflc_pkg::VERDICT_FEW_FIELDS;
         r.verdict_detail = field_count[2:0];
         return r;
      end
      // Timezone fields before the year are skipped when not numeric.
      sel = mflc_pkg::NUM_YEAR;
      if (field_count > FULL_FIELDS && !num_digit[sel]) sel = mflc_pkg::NUM_YEAR + 1;
      if (field_count > FULL_FIELDS + 1 && !num_digit[sel]) sel = mflc_pkg::NUM_YEAR + 2;
      day_ok = 1'b0;
      month_ok = 1'b0;
      for (int k = 0; k < 7; k++)
         if (wday_fill == 2'd3 && wday_win == DAY_CODES[k]) day_ok = 1'b1;
      for (int k = 0; k < 12; k++)
         if (mon_fill == 2'd3 && mon_win == MONTH_CODES[k]) month_ok = 1'b1;
      if (!day_ok) begin
         r.verdict = mflc_pkg::VERDICT_BAD_WEEKDAY;
         return r;
      end
      if (!month_ok) begin
         r.verdict = mflc_pkg::VERDICT_BAD_MONTH;
         return r;
      end
      for (int k = 0; k < mflc_pkg::NUM_CHECKS; k++) begin
         slot = (k < mflc_pkg::NUM_YEAR) ? k : sel;
         if (!num_digit[slot]) begin
            r.verdict = mflc_pkg::VERDICT_NOT_DIGIT;
            r.verdict_detail = k[2:0];
            return r;
         end
         if (num_val[slot] < mflc_pkg::NUM_LOW[k] || num_val[slot] > mflc_pkg::NUM_HIGH[k]) begin
            r.verdict = mflc_pkg::VERDICT_RANGE;
            r.verdict_detail = k[2:0];
            return r;
         end
      end
      return r;
   endfunction

   task automatic note_failure(input string what);
      if (mismatches < REPORT_LIMIT) $display("%t: %s", $realtime, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_scan();
         awaited_verdicts.delete();
      end else begin
         if (req_valid && !req_stall) begin
            scan_byte(req_payload.text_byte);
            if (req_payload.line_end) begin
               awaited_verdicts.push_back(line_verdict());
               clear_scan();
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_verdicts.size() == 0) begin
               note_failure($sformatf("response with no line pending: verdict %0d detail %0d",
                                      rsp_payload.verdict, rsp_payload.verdict_detail));
            end else begin
               want = awaited_verdicts.pop_front();
               if (rsp_payload.verdict !== want.verdict)
                  note_failure($sformatf("verdict mismatch: expected %0d, got %0d",
                                         want.verdict, rsp_payload.verdict));
               if (rsp_payload.verdict_detail !== want.verdict_detail)
                  note_failure($sformatf("detail mismatch: expected %0d, got %0d",
                                         want.verdict_detail, rsp_payload.verdict_detail));
            end
         end
      end
      pending_verdicts <= awaited_verdicts.size();
      fail_count <= mismatches;
   end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the mbox "From " line checker: directed lines for
// each corner of the line format, then random well-formed, broken and noise
// lines under random idling on both channels, checked by a separate monitor.
// ----------------------------------------------------------------------------
module tb;

   localparam int ITEM_TARGET = 950;
   localparam int LINE_TARGET = 9;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [7:0] CHAR_NL = 8'd10;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   mflc_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   mflc_pkg::rsp_type rsp_payload;

   int fail_count;
   int pending_verdicts;

   // Stimulus controls shared between the sender and the receiver process.
   bit quiet_mode = 1'b0;
   bit hold_request = 1'b0;
   bit hold_served = 1'b0;

   logic [7:0] line_buf[$];
   int sent_bytes = 0;
   int random_lines = 0;

   string day_pool[7] = '{"Sun", "Mon", "Tue", "Wed", "Thu", "Fri", "Sat"};
   string month_pool[12] = '{"Jan", "Feb", "Mar", "Apr", "May", "Jun",
                             "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"};
   string zone_pool[4] = '{"PST", "+0100", "EDT", "-0500"};

   always #5 clock = ~clock;

   mbox_from_line_checker_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // The monitor sees every transfer on both channels, predicts each line's
   // verdict and reports the failure count and the number of open lines.
   mflc_verdict_checker verdict_monitor (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .fail_count       (fail_count),
      .pending_verdicts (pending_verdicts)
   );

   // One byte transfer. Now and then req_valid is dropped for idling first, unless the
   // quiet stretch is running. The task returns at the edge where the byte
   // was taken, so the caller can present the next byte in the same step.
   task automatic send_byte(input logic [7:0] b, input logic last);
      if (!quiet_mode && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= {b, last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Sends the buffered line with line_end on its final byte.
   task automatic send_line();
      sent_bytes += line_buf.size();
      for (int i = 0; i < line_buf.size(); i++)
         send_byte(line_buf[i], i == line_buf.size() - 1);
      line_buf.delete();
   endtask

   task automatic append_text(input string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endtask

   task automatic directed(input string s);
      append_text(s);
      send_line();
   endtask

   // Mostly plain spaces, sometimes the other blank characters. Newline is
   // left out on purpose because it terminates the line.
   task automatic append_blank();
      int pick;
      int count;
      count = $urandom_range(2, 1);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(9);
         case (pick)
            0: line_buf.push_back(8'd9);
            1: line_buf.push_back(8'd11);
            2: line_buf.push_back(8'd12);
            3: line_buf.push_back(8'd13);
            default: line_buf.push_back(8'd32);
         endcase
      end
   endtask

   // A decimal field that is usually legal, sometimes just outside its range,
   // sometimes huge enough to saturate, padded with zeros, or not numeric.
   function automatic string number_text(input int lo, input int hi);
      int pick;
      int v;
      string s;
      pick = $urandom_range(99);
      if (pick < 70) v = $urandom_range(hi, lo);
      else if (pick < 75) v = (lo > 0) ? lo - 1 : hi + 1;
      else if (pick < 80) v = hi + 1;
      else if (pick < 85) v = $urandom_range(999999, 4000);
      else v = $urandom_range(hi, lo);
      s = $sformatf("%0d", v);
      if (pick >= 85 && pick < 90) s = {"x", s};
      else if (pick >= 90) s = {"00", s};
      if ($urandom_range(9) == 0) s = {s, "q"};
      return s;
   endfunction

   function automatic string name_text(input string name);
      int pick;
      string s;
      pick = $urandom_range(99);
      if (pick < 80) return name;
      s = "";
      for (int i = 0; i < $urandom_range(4, 1); i++)
         s = {s, string'(8'($urandom_range(122, 65)))};
      if (pick < 90) s = {name, s};
      return s;
   endfunction

   // A "From " line with random content in every field.
   task automatic build_from_line();
      int pick;
      if ($urandom_range(19) == 0) begin
         append_text("From ");
         line_buf[$urandom_range(4)] = 8'($urandom_range(255));
      end else begin
         append_text("From ");
      end
      for (int i = 0; i < $urandom_range(8, 1); i++)
         line_buf.push_back(8'($urandom_range(126, 33)));
      append_blank();
      append_text(name_text(day_pool[$urandom_range(6)]));
      append_blank();
      append_text(name_text(month_pool[$urandom_range(11)]));
      append_blank();
      append_text(number_text(1, 31));
      append_blank();
      pick = $urandom_range(99);
      if (pick < 85) begin
         append_text({number_text(0, 23), ":", number_text(0, 59), ":",
                      number_text(0, 60)});
      end else if (pick < 92) begin
         // Colon that opens the hour or minute field.
         append_text({":", number_text(0, 59), ":", number_text(0, 60)});
      end else begin
         append_text(number_text(0, 23));
         append_blank();
         append_text(number_text(0, 59));
      end
      if ($urandom_range(3) == 0) begin
         for (int i = 0; i < $urandom_range(2, 1); i++) begin
            append_blank();
            append_text(zone_pool[$urandom_range(3)]);
         end
      end
      append_blank();
      append_text(number_text(1969, 2199));
      if ($urandom_range(4) == 0) begin
         for (int i = 0; i < $urandom_range(3, 1); i++) begin
            append_blank();
            append_text(number_text(0, 99));
         end
      end
      pick = $urandom_range(99);
      if (pick < 20) begin
         line_buf.push_back(CHAR_NL);
         if (pick < 10) append_text("junk 12");
      end else if (pick < 28) begin
         line_buf.push_back(8'd0);
         append_text(" more");
      end
      if ($urandom_range(19) == 0)
         line_buf.insert($urandom_range(line_buf.size() - 1),
                         8'($urandom_range(255, 128)));
      if ($urandom_range(19) == 0)
         line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
   endtask

   // The receiver stalls at random, except for one long hold-off that the
   // sender requests and this process counts out on its own.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request && !hold_served) begin
            hold_served = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= !quiet_mode && ($urandom_range(99) < 14);
         end
      end
   end

   // Watchdog: ends the run when nothing is transferred on either channel
   // for too long. The longest legal quiet spell is the long hold-off.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("tb failed");
      $finish;
   end

   initial begin
      int kind;
      int keep;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed lines: the legal extremes, every verdict and the corners of
      // the format. The newline-terminated one ends with line_end on '\n'.
      directed("From alice Sun Jan 1 00:00:00 1969");
      directed({"From bob Sat Dec 31 23:59:60 2199", string'(CHAR_NL)});
      directed("Fro");
      directed("from a Mon Feb 3 4:5:6 2000");
      directed("From");
      directed("From a Mon Feb 3 04:05");
      directed("From ");
      directed("From a Mo Feb 3 4:5:6 2000");
      directed("From a Mon Fe 3 4:5:6 2000");
      directed("From a Monday Febr 3 4:5:6 2000");
      directed("From a Tue Mar x 4:5:6 2000");
      directed("From a Wed Apr 32 4:5:6 2000");
      directed("From a Thu May 0 24:5:6 2000");
      directed("From a Fri Jun 9 1:60:61 2000");
      directed("From a Sat Jul 9 1:2:61 1968");
      directed("From a Sun Aug 9 1:2:3 2200");
      directed("From a Mon Sep 9 10:11:12 PST 2001");
      directed("From a Tue Oct 9 10:11:12 PST EDT 2001");
      directed("From a Wed Nov 9 1:2:3 A B C 2001");
      directed("From a Thu Dec 99999 1:2:3 2000");
      directed("From a Fri Jan 9 1:2:3 1999 x y z w v");
      directed("From a Sat Feb 9 :5 6 2000");
      directed("From a\tMon\vMar\f4\r1:2:3 2000");
      // A terminator after the prefix hides everything that follows.
      append_text("From a Sun Jul 4 1:2:3 1999");
      line_buf.push_back(CHAR_NL);
      directed("xyz");
      append_text("From a Sun Jul 4 1:2:3 1999");
      line_buf.push_back(8'd0);
      directed(" 2 3");
      // A non-ASCII byte fills the remaining fields as empty.
      append_text("From a Sun Aug 4 1:2:3 ");
      line_buf.push_back(8'd200);
      directed(" 2000");

      // Random part: mostly well-formed lines with random content, mixed
      // at random with truncated lines and raw noise.
      while (sent_bytes < ITEM_TARGET || random_lines < LINE_TARGET) begin
         // A stretch with no idling on either side.
         quiet_mode = (random_lines < 4);
         // Long receiver hold-off while the sender keeps offering lines.
         if (random_lines == 4) hold_request = 1'b1;
         // Sender pause until every open line has its verdict.
         if (random_lines == 8) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (pending_verdicts != 0);
         end
         kind = $urandom_range(99);
         if (kind < 70) begin
            build_from_line();
         end else if (kind < 85) begin
            build_from_line();
            keep = $urandom_range(line_buf.size() - 1, 1);
            while (line_buf.size() > keep) void'(line_buf.pop_back());
         end else begin
            if (kind < 90) append_text("From ");
            for (int i = 0; i < $urandom_range(12, 1); i++)
               line_buf.push_back(8'($urandom_range(255)));
         end
         random_lines++;
         send_line();
      end
      quiet_mode = 1'b0;

      // Drain: wait for every verdict, then wait on for anything the block
      // might still produce.
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_verdicts != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
